// ===== rtl/ilir_pkg.sv =====
package ilir_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int ELEM_BITS_DEF = 32;
  localparam int FUNC_W        = 4;
  localparam int STATUS_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 4'd0,
    FN_POP    = 4'd1,
    FN_INSERT = 4'd2,
    FN_REMOVE = 4'd3,
    FN_READ   = 4'd4,
    FN_WRITE  = 4'd5,
    FN_SWAP   = 4'd6,
    FN_FRONT  = 4'd7,
    FN_BACK   = 4'd8,
    FN_CLEAR  = 4'd9,
    FN_RESIZE = 4'd10
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_WRITE  = 3'd1,
    CELL_INSERT = 3'd2,
    CELL_REMOVE = 3'd3,
    CELL_FILL   = 3'd4,
    CELL_SWAP   = 3'd5
  } cell_op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SWAP = 1'b1
  } state_t;

endpackage

// ===== rtl/ilir_if.sv =====
interface ilir_in_if #(
  parameter int CNT_W  = $clog2(ilir_pkg::DEPTH_DEF + 1),
  parameter int IDX_W  = $clog2(ilir_pkg::DEPTH_DEF),
  parameter int DATA_W = ilir_pkg::ELEM_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [ilir_pkg::FUNC_W-1:0] func;
  logic [CNT_W-1:0]            index;
  logic [IDX_W-1:0]            second_index;
  logic [DATA_W-1:0]           value;
  logic [CNT_W-1:0]            new_count;

  modport source (output valid, func, index, second_index, value, new_count, input ready);
  modport sink   (input valid, func, index, second_index, value, new_count, output ready);
endinterface

interface ilir_out_if #(
  parameter int CNT_W  = $clog2(ilir_pkg::DEPTH_DEF + 1),
  parameter int DATA_W = ilir_pkg::ELEM_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [ilir_pkg::STATUS_W-1:0] status;
  logic [DATA_W-1:0]             read_data;
  logic [CNT_W-1:0]              count;
  logic                          empty_res;

  modport source (output valid, status, read_data, count, empty_res, input ready);
  modport sink   (input valid, status, read_data, count, empty_res, output ready);
endinterface

// ===== rtl/ilir_cell.sv =====
module ilir_cell #(
  parameter int DEPTH        = ilir_pkg::DEPTH_DEF,
  parameter int ELEMENT_BITS = ilir_pkg::ELEM_BITS_DEF,
  parameter int POS          = 0
) (
  input  logic                             clk,
  input  ilir_pkg::cell_op_t               op,
  input  logic [$clog2(DEPTH+1)-1:0]       idx,
  input  logic [$clog2(DEPTH)-1:0]         idx2,
  input  logic [$clog2(DEPTH+1)-1:0]       cnt,
  input  logic [$clog2(DEPTH+1)-1:0]       target,
  input  logic [ELEMENT_BITS-1:0]          value,
  input  logic [ELEMENT_BITS-1:0]          left_q,
  input  logic [ELEMENT_BITS-1:0]          right_q,
  input  logic [ELEMENT_BITS-1:0]          bus,
  input  logic [ELEMENT_BITS-1:0]          tmp,
  output logic [ELEMENT_BITS-1:0]          q
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] POS_C  = CNT_W'(POS);
  localparam logic [CNT_W-1:0] POS1_C = CNT_W'(POS + 1);
  localparam logic [IDX_W-1:0] POS_A  = IDX_W'(POS);

  logic [ELEMENT_BITS-1:0] q_r;
  logic [ELEMENT_BITS-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    case (op)
      ilir_pkg::CELL_WRITE: begin
        if (POS_C == idx) q_nxt = value;
      end
      ilir_pkg::CELL_INSERT: begin
        if (POS_C == idx) q_nxt = value;
        else if (POS_C > idx && POS_C <= cnt) q_nxt = left_q;
      end
      ilir_pkg::CELL_REMOVE: begin
        if (POS_C >= idx && POS1_C < cnt) q_nxt = right_q;
      end
      ilir_pkg::CELL_FILL: begin
        if (POS_C >= cnt && POS_C < target) q_nxt = value;
      end
      ilir_pkg::CELL_SWAP: begin
        if (POS_C == idx) q_nxt = bus;
        else if (POS_A == idx2) q_nxt = tmp;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ===== rtl/indexed_list_insert_remove.sv =====
// Ordered list of up to DEPTH words held in a row of cells, one entry per cell.
// Insert and remove shift every later entry at once, so push, pop, insert,
// remove, read, write, front, back, clear and resize each give one result.
// Swap also gives one result: the single read mux over the cells fetches the
// first entry on acceptance, into tmp_r, and the second entry in ST_SWAP.
// A new item is taken while no swap is in progress and the result register is
// free or being drained. Reset clears the count; entries above the count hold
// no meaning and are never read.
module indexed_list_insert_remove #(
  parameter int DEPTH        = ilir_pkg::DEPTH_DEF,
  parameter int ELEMENT_BITS = ilir_pkg::ELEM_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ilir_in_if.sink    in_item,
  ilir_out_if.source out_item
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  ilir_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [IDX_W-1:0]        idx2_r, idx2_nxt;
  logic [ELEMENT_BITS-1:0] tmp_r, tmp_nxt;

  logic                    out_valid_r, out_valid_nxt;
  ilir_pkg::status_t       out_status_r, out_status_nxt;
  logic [ELEMENT_BITS-1:0] out_data_r, out_data_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  logic                    out_empty_r, out_empty_nxt;

  logic [ELEMENT_BITS-1:0] cell_q [DEPTH];
  logic [ELEMENT_BITS-1:0] rd_data;
  logic [IDX_W-1:0]        rd_addr;
  ilir_pkg::cell_op_t      cell_op;
  logic [CNT_W-1:0]        cell_idx;
  logic [IDX_W-1:0]        cell_idx2;

  logic                    accept;
  logic [CNT_W-1:0]        idx2_ext;
  ilir_pkg::func_t         func;

  assign func     = ilir_pkg::func_t'(in_item.func);
  assign idx2_ext = CNT_W'(in_item.second_index);
  assign in_item.ready = (state_r == ilir_pkg::ST_IDLE) && (!out_valid_r || out_item.ready);
  assign accept   = in_item.valid && in_item.ready;

  always_comb begin
    if (state_r == ilir_pkg::ST_SWAP) begin
      rd_addr = idx2_r;
    end else if (func == ilir_pkg::FN_FRONT) begin
      rd_addr = '0;
    end else if (func == ilir_pkg::FN_BACK) begin
      rd_addr = IDX_W'(cnt_r - ONE_C);
    end else begin
      rd_addr = in_item.index[IDX_W-1:0];
    end
  end

  assign rd_data = cell_q[rd_addr];

  always_comb begin
    logic                    load;
    logic                    go_swap;
    ilir_pkg::status_t       st;
    logic [ELEMENT_BITS-1:0] rd;
    logic [CNT_W-1:0]        cn;

    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    idx2_nxt  = idx2_r;
    tmp_nxt   = tmp_r;
    cell_op   = ilir_pkg::CELL_HOLD;
    cell_idx  = in_item.index;
    cell_idx2 = idx2_r;
    load      = 1'b0;
    go_swap   = 1'b0;
    st        = ilir_pkg::STAT_OK;
    rd        = '0;
    cn        = cnt_r;

    unique case (state_r)
      ilir_pkg::ST_IDLE: begin
        unique case (func) inside
          ilir_pkg::FN_PUSH: begin
            if (cnt_r == DEPTH_C) begin
              st = ilir_pkg::STAT_FULL;
            end else begin
              cell_op  = ilir_pkg::CELL_WRITE;
              cell_idx = cnt_r;
              cn       = cnt_r + ONE_C;
            end
          end
          ilir_pkg::FN_POP: begin
            if (cnt_r == '0) st = ilir_pkg::STAT_EMPTY;
            else cn = cnt_r - ONE_C;
          end
          ilir_pkg::FN_INSERT: begin
            if (in_item.index > cnt_r) begin
              st = ilir_pkg::STAT_BAD_INDEX;
            end else if (cnt_r == DEPTH_C) begin
              st = ilir_pkg::STAT_FULL;
            end else begin
              cell_op = ilir_pkg::CELL_INSERT;
              cn      = cnt_r + ONE_C;
            end
          end
          ilir_pkg::FN_REMOVE: begin
            if (in_item.index >= cnt_r) begin
              st = ilir_pkg::STAT_BAD_INDEX;
            end else begin
              cell_op = ilir_pkg::CELL_REMOVE;
              cn      = cnt_r - ONE_C;
            end
          end
          ilir_pkg::FN_READ: begin
            if (in_item.index >= cnt_r) st = ilir_pkg::STAT_BAD_INDEX;
            else rd = rd_data;
          end
          ilir_pkg::FN_WRITE: begin
            if (in_item.index >= cnt_r) st = ilir_pkg::STAT_BAD_INDEX;
            else cell_op = ilir_pkg::CELL_WRITE;
          end
          ilir_pkg::FN_SWAP: begin
            if (in_item.index >= cnt_r || idx2_ext >= cnt_r) begin
              st = ilir_pkg::STAT_BAD_INDEX;
            end else begin
              go_swap = 1'b1;
            end
          end
          ilir_pkg::FN_FRONT, ilir_pkg::FN_BACK: begin
            if (cnt_r == '0) st = ilir_pkg::STAT_EMPTY;
            else rd = rd_data;
          end
          ilir_pkg::FN_CLEAR: begin
            cn = '0;
          end
          ilir_pkg::FN_RESIZE: begin
            if (in_item.new_count > DEPTH_C) begin
              st = ilir_pkg::STAT_FULL;
            end else begin
              cell_op = ilir_pkg::CELL_FILL;
              cn      = in_item.new_count;
            end
          end
          default: begin
            st = ilir_pkg::STAT_BAD_INDEX;
          end
        endcase

        if (!accept) begin
          cell_op = ilir_pkg::CELL_HOLD;
        end else if (go_swap) begin
          state_nxt = ilir_pkg::ST_SWAP;
          idx_nxt   = in_item.index[IDX_W-1:0];
          idx2_nxt  = in_item.second_index;
          tmp_nxt   = rd_data;
        end else begin
          load    = 1'b1;
          cnt_nxt = cn;
        end
      end
      ilir_pkg::ST_SWAP: begin
        cell_op   = ilir_pkg::CELL_SWAP;
        cell_idx  = CNT_W'(idx_r);
        load      = 1'b1;
        state_nxt = ilir_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ilir_pkg::ST_IDLE;
      end
    endcase

    out_valid_nxt  = load ? 1'b1 : (out_item.ready ? 1'b0 : out_valid_r);
    out_status_nxt = load ? st : out_status_r;
    out_data_nxt   = load ? rd : out_data_r;
    out_count_nxt  = load ? cn : out_count_r;
    out_empty_nxt  = load ? (cn == '0) : out_empty_r;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left_q;
    logic [ELEMENT_BITS-1:0] right_q;

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_left
      assign left_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_right
      assign right_q = cell_q[i+1];
    end

    ilir_cell #(
      .DEPTH        (DEPTH),
      .ELEMENT_BITS (ELEMENT_BITS),
      .POS          (i)
    ) u_cell (
      .clk     (clk),
      .op      (cell_op),
      .idx     (cell_idx),
      .idx2    (cell_idx2),
      .cnt     (cnt_r),
      .target  (in_item.new_count),
      .value   (in_item.value),
      .left_q  (left_q),
      .right_q (right_q),
      .bus     (rd_data),
      .tmp     (tmp_r),
      .q       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilir_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    idx2_r       <= idx2_nxt;
    tmp_r        <= tmp_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign out_item.valid     = out_valid_r;
  assign out_item.status    = out_status_r;
  assign out_item.read_data = out_data_r;
  assign out_item.count     = out_count_r;
  assign out_item.empty_res = out_empty_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C)
    else $error("entry count above capacity");

  a_swap_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ilir_pkg::ST_SWAP |=> state_r == ilir_pkg::ST_IDLE)
    else $error("swap did not finish in its second cycle");

  a_swap_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ilir_pkg::ST_SWAP |-> !out_valid_r)
    else $error("result register busy during swap");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_count_r == '0)))
    else $error("empty flag disagrees with count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && func == ilir_pkg::FN_CLEAR |=> cnt_r == '0)
    else $error("clear left entries");

endmodule
